### src/lexical_token_scanner_unit_defines.svh
// Assertion macros for the lexical token scanner.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef LEXICAL_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define LEXICAL_TOKEN_SCANNER_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define LTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked at every edge out of reset
`define LTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/lts_pkg.sv
// Shared types and constants for the lexical token scanner.
// No dependencies; imported by every module of the block.
package lts_pkg;

    localparam int KEYWORD_SLOTS_DEF = 32;
    localparam int KEYWORD_LEN_DEF   = 16;
    localparam int TOKEN_LEN_DEF     = 32;
    localparam int LINE_LEN_DEF      = 1024;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [1:0] {
        CMD_SRC = 2'd0,
        CMD_EOL = 2'd1,
        CMD_KWC = 2'd2,
        CMD_KWE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STAR, M_LT, M_GT, M_COLON
    } t_mode;

    localparam logic [2:0] K_RESERVED = 3'd0;
    localparam logic [2:0] K_IDENT    = 3'd1;
    localparam logic [2:0] K_INTEGER  = 3'd2;
    localparam logic [2:0] K_OPERATOR = 3'd3;
    localparam logic [2:0] K_DELIM    = 3'd4;
    localparam logic [2:0] K_BADCHAR  = 3'd5;
    localparam logic [2:0] K_DIGLET   = 3'd6;
    localparam logic [2:0] K_COLON    = 3'd7;

    localparam logic [3:0] OP_MINUS = 4'd0;
    localparam logic [3:0] OP_STAR  = 4'd1;
    localparam logic [3:0] OP_SLASH = 4'd2;
    localparam logic [3:0] OP_PLUS  = 4'd3;
    localparam logic [3:0] OP_EQ    = 4'd4;
    localparam logic [3:0] OP_LT    = 4'd5;
    localparam logic [3:0] OP_GT    = 4'd6;
    localparam logic [3:0] OP_AT    = 4'd7;
    localparam logic [3:0] OP_CARET = 4'd8;
    localparam logic [3:0] OP_POW   = 4'd9;
    localparam logic [3:0] OP_NE    = 4'd10;
    localparam logic [3:0] OP_LE    = 4'd11;
    localparam logic [3:0] OP_GE    = 4'd12;
    localparam logic [3:0] OP_ASSIGN = 4'd13;

    localparam logic [3:0] D_LPAREN = 4'd0;
    localparam logic [3:0] D_RPAREN = 4'd1;
    localparam logic [3:0] D_LBRACE = 4'd2;
    localparam logic [3:0] D_RBRACE = 4'd3;
    localparam logic [3:0] D_COMMA  = 4'd4;
    localparam logic [3:0] D_SEMI   = 4'd5;
    localparam logic [3:0] CODE_NONE = 4'd0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  code;
        logic [4:0]  keyword_index;
        logic [5:0]  token_length;
        logic [15:0] line_number;
        logic [9:0]  start_column;
        logic        last;
    } t_res;

    // control broadcast to every keyword cell
    typedef struct packed {
        logic wr_char;   // store keyword char in the owning cell
        logic kw_end;    // close the owning cell, pass ownership on
        logic start;     // first letter of an identifier
        logic extend;    // further letter or digit of an identifier
        logic overflow;  // identifier already at full length
    } t_cell_ctl;

endpackage

### src/lexical_token_scanner_unit.sv
// Lexical token scanner: one request per cycle while o_stall is low.
// A request is classified in the cycle it is taken; its results are registered
// into a 4-entry queue that drives o_res. A request is taken when the
// queue has room for two results; results leave at one per cycle while i_stall is low.
// Synchronous active-low reset clears scan state, line count to 1, empties the
// table; keyword characters themselves are not cleared.
module lexical_token_scanner_unit
    import lts_pkg::*;
#(
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int KEYWORD_LEN   = KEYWORD_LEN_DEF,
    parameter int TOKEN_LEN     = TOKEN_LEN_DEF,
    parameter int LINE_LEN      = LINE_LEN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);
`include "lexical_token_scanner_unit_defines.svh"

    localparam int PW  = $clog2(TOKEN_LEN+1);
    localparam int LW  = $clog2(KEYWORD_LEN+1);
    localparam int CW  = $clog2(LINE_LEN);
    localparam int SIW = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;

    t_mode         r_mode, n_mode;
    logic [PW-1:0] r_len, n_len;
    logic [CW-1:0] r_start, n_start, r_col, n_col;
    logic [15:0]   r_line, n_line;
    logic [LW-1:0] r_lpos, n_lpos;

    t_cell_ctl     ctl;
    logic [KEYWORD_SLOTS-1:0] own, used, hit;
    logic          full, any_hit, fire, room2;
    logic [SIW-1:0] hit_idx;
    logic          v_e, v_f, v_g, letter, digit, used_ch;
    logic          pair;
    logic [3:0]    p_code;
    logic [2:0]    g_kind;
    logic [3:0]    g_code;
    t_res          e_item, f_item, g_item, d0, d1;
    logic [1:0]    push;
    logic [7:0]    ch;

    function automatic t_res mk(input logic [2:0] kind, input logic [3:0] code,
                                input logic [4:0] kwi, input logic [5:0] len,
                                input logic [9:0] col, input logic [15:0] line);
        t_res r;
        r.kind          = kind;
        r.code          = code;
        r.keyword_index = kwi;
        r.token_length  = len;
        r.line_number   = line;
        r.start_column  = col;
        r.last          = 1'b0;
        return r;
    endfunction

    genvar g;
    generate
        for (g = 0; g < KEYWORD_SLOTS; g++) begin : gen_cell
            lts_cell #(
                .KEYWORD_LEN (KEYWORD_LEN),
                .TOKEN_LEN   (TOKEN_LEN)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_first    (g == 0),
                .i_ctl      (ctl),
                .i_ch       (ch),
                .i_pos      (ctl.start ? '0 : r_len),
                .i_load_pos (r_lpos),
                .i_prev_own ((g == 0) ? 1'b0 : own[(g == 0) ? 0 : g-1]),
                .o_own      (own[g]),
                .o_used     (used[g]),
                .o_hit      (hit[g])
            );
        end
    endgenerate

    assign full = used[KEYWORD_SLOTS-1];
    assign ch   = i_req.ch;
    assign fire = i_valid && !o_stall;
    assign o_stall = !room2;

    // lowest matching slot wins
    always_comb begin
        any_hit = |hit;
        hit_idx = '0;
        for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) hit_idx = SIW'(i);
        end
    end

    always_comb begin
        letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
        digit  = (ch >= 8'h30) && (ch <= 8'h39);
    end

    // token in progress, as reported when it is cut off or completed as a pair
    always_comb begin
        f_item = mk(K_IDENT, CODE_NONE, 5'd0, 6'(r_len), 10'(r_start), r_line);
        unique case (r_mode)
            M_IDENT: begin
                if (any_hit) begin
                    f_item = mk(K_RESERVED, CODE_NONE, 5'(hit_idx), 6'(r_len), 10'(r_start), r_line);
                end
            end
            M_NUMBER: f_item = mk(K_INTEGER, CODE_NONE, 5'd0, 6'(r_len), 10'(r_start), r_line);
            M_STAR:   f_item = mk(K_OPERATOR, OP_STAR, 5'd0, 6'd0, 10'(r_start), r_line);
            M_LT:     f_item = mk(K_OPERATOR, OP_LT, 5'd0, 6'd0, 10'(r_start), r_line);
            M_GT:     f_item = mk(K_OPERATOR, OP_GT, 5'd0, 6'd0, 10'(r_start), r_line);
            M_COLON:  f_item = mk(K_COLON, CODE_NONE, 5'd0, 6'd0, 10'(r_start), r_line);
            M_IDLE:   f_item = mk(K_IDENT, CODE_NONE, 5'd0, 6'(r_len), 10'(r_start), r_line);
            default:  f_item = mk(K_IDENT, CODE_NONE, 5'd0, 6'(r_len), 10'(r_start), r_line);
        endcase
        if (pair) begin
            f_item = mk(K_OPERATOR, p_code, 5'd0, 6'd0, 10'(r_start), r_line);
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_start = r_start;
        n_col   = r_col;
        n_line  = r_line;
        n_lpos  = r_lpos;
        ctl     = '0;
        v_e     = 1'b0;
        v_f     = 1'b0;
        v_g     = 1'b0;
        used_ch = 1'b0;
        pair    = 1'b0;
        p_code  = CODE_NONE;
        g_kind  = K_BADCHAR;
        g_code  = CODE_NONE;
        e_item  = mk(K_DIGLET, CODE_NONE, 5'd0, 6'(r_len), 10'(r_start), r_line);
        if (fire) begin
            unique case (t_cmd'(i_req.cmd))
                CMD_SRC: begin
                    unique case (r_mode)
                        M_IDENT: begin
                            if (letter || digit) begin
                                used_ch      = 1'b1;
                                ctl.extend   = 1'b1;
                                ctl.overflow = (32'(r_len) >= 32'(TOKEN_LEN));
                                if (!ctl.overflow) n_len = r_len + PW'(1);
                            end
                        end
                        M_NUMBER: begin
                            if (digit) begin
                                used_ch = 1'b1;
                                if (32'(r_len) < 32'(TOKEN_LEN)) n_len = r_len + PW'(1);
                            end else begin
                                v_e = letter;
                            end
                        end
                        M_STAR: begin
                            if (ch == CH_STAR) begin
                                used_ch = 1'b1;
                                pair    = 1'b1;
                                p_code  = OP_POW;
                            end
                        end
                        M_LT: begin
                            if (ch == CH_GT) begin
                                used_ch = 1'b1;
                                pair    = 1'b1;
                                p_code  = OP_NE;
                            end else if (ch == CH_EQ) begin
                                used_ch = 1'b1;
                                pair    = 1'b1;
                                p_code  = OP_LE;
                            end
                        end
                        M_GT: begin
                            if (ch == CH_EQ) begin
                                used_ch = 1'b1;
                                pair    = 1'b1;
                                p_code  = OP_GE;
                            end
                        end
                        M_COLON: begin
                            if (ch == CH_EQ) begin
                                used_ch = 1'b1;
                                pair    = 1'b1;
                                p_code  = OP_ASSIGN;
                            end
                        end
                        M_IDLE: ;
                        default: ;
                    endcase
                    if (pair) begin
                        v_f    = 1'b1;
                        n_mode = M_IDLE;
                    end
                    if (!used_ch) begin
                        v_f    = (r_mode != M_IDLE);
                        n_mode = M_IDLE;
                        if (letter) begin
                            n_mode    = M_IDENT;
                            n_start   = r_col;
                            n_len     = PW'(1);
                            ctl.start = 1'b1;
                        end else if (digit) begin
                            n_mode  = M_NUMBER;
                            n_start = r_col;
                            n_len   = PW'(1);
                        end else begin
                            // start and length only matter once a mode is entered
                            n_start = r_col;
                            n_len   = '0;
                            v_g     = 1'b1;
                            priority case (ch)
                                CH_SPACE, CH_TAB: v_g = 1'b0;
                                CH_STAR:  begin v_g = 1'b0; n_mode = M_STAR;  end
                                CH_LT:    begin v_g = 1'b0; n_mode = M_LT;    end
                                CH_GT:    begin v_g = 1'b0; n_mode = M_GT;    end
                                CH_COLON: begin v_g = 1'b0; n_mode = M_COLON; end
                                CH_MINUS: begin g_kind = K_OPERATOR; g_code = OP_MINUS; end
                                CH_SLASH: begin g_kind = K_OPERATOR; g_code = OP_SLASH; end
                                CH_PLUS:  begin g_kind = K_OPERATOR; g_code = OP_PLUS;  end
                                CH_EQ:    begin g_kind = K_OPERATOR; g_code = OP_EQ;    end
                                CH_AT:    begin g_kind = K_OPERATOR; g_code = OP_AT;    end
                                CH_CARET: begin g_kind = K_OPERATOR; g_code = OP_CARET; end
                                CH_LPAR:  begin g_kind = K_DELIM; g_code = D_LPAREN; end
                                CH_RPAR:  begin g_kind = K_DELIM; g_code = D_RPAREN; end
                                CH_LBRC:  begin g_kind = K_DELIM; g_code = D_LBRACE; end
                                CH_RBRC:  begin g_kind = K_DELIM; g_code = D_RBRACE; end
                                CH_COMMA: begin g_kind = K_DELIM; g_code = D_COMMA;  end
                                CH_SEMI:  begin g_kind = K_DELIM; g_code = D_SEMI;   end
                                default:  ;
                            endcase
                        end
                    end
                    if (32'(r_col) < 32'(LINE_LEN - 1)) n_col = r_col + CW'(1);
                end
                CMD_EOL: begin
                    v_f    = (r_mode != M_IDLE);
                    n_mode = M_IDLE;
                    if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                    n_col  = '0;
                end
                CMD_KWC: begin
                    if (!full && (32'(r_lpos) < 32'(KEYWORD_LEN))) begin
                        ctl.wr_char = 1'b1;
                        n_lpos      = r_lpos + LW'(1);
                    end
                end
                CMD_KWE: begin
                    ctl.kw_end = !full;
                    n_lpos     = '0;
                end
                default: ;
            endcase
        end
        g_item = mk(g_kind, g_code, 5'd0, 6'd0, 10'(r_col), r_line);
    end

    // pack up to two results in order: digit-letter error, cut-off token, new one
    always_comb begin
        d0   = v_e ? e_item : (v_f ? f_item : g_item);
        d1   = v_e ? f_item : g_item;
        push = 2'(v_e) + 2'(v_f) + 2'(v_g);
        if (push == 2'd1) d0.last = 1'b1;
        if (push == 2'd2) d1.last = 1'b1;
    end

    lts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_d0    (d0),
        .i_d1    (d1),
        .o_room2 (room2),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_len   <= '0;
            r_start <= '0;
            r_col   <= '0;
            r_line  <= 16'd1;
            r_lpos  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_start <= n_start;
            r_col   <= n_col;
            r_line  <= n_line;
            r_lpos  <= n_lpos;
        end
    end

    // load ownership is a single token travelling down the cells
    `LTS_ASSERT_ALWAYS(a_own_onehot, $onehot0(own), "more than one cell owns the keyword load")
    `LTS_ASSERT_IMPL(a_line_nonzero, o_valid, o_res.line_number != 16'd0, "line number zero")
    `LTS_ASSERT_IMPL(a_reserved_len, o_valid && (o_res.kind == K_RESERVED), o_res.token_length != 6'd0, "reserved word of zero length")
endmodule

### src/lts_cell.sv
// One keyword slot: stored word, length and match state for the current identifier.
// Depends on lts_pkg; load ownership passes to the next cell in the chain.
module lts_cell
    import lts_pkg::*;
#(
    parameter int KEYWORD_LEN = KEYWORD_LEN_DEF,
    parameter int TOKEN_LEN   = TOKEN_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_first,
    input  t_cell_ctl                        i_ctl,
    input  logic [7:0]                       i_ch,
    input  logic [$clog2(TOKEN_LEN+1)-1:0]   i_pos,
    input  logic [$clog2(KEYWORD_LEN+1)-1:0] i_load_pos,
    input  logic                             i_prev_own,
    output logic                             o_own,
    output logic                             o_used,
    output logic                             o_hit
);
    localparam int PW  = $clog2(TOKEN_LEN+1);
    localparam int LW  = $clog2(KEYWORD_LEN+1);
    localparam int KIW = $clog2(KEYWORD_LEN);

    logic [7:0]    r_chars [KEYWORD_LEN];
    logic [LW-1:0] r_klen;
    logic          r_own, r_used, r_mask, r_hit;
    logic          n_mask;
    logic          cmp;
    logic [PW+KIW-1:0] posx;
    logic [LW+KIW-1:0] lposx;

    assign posx  = (PW+KIW)'(i_pos);
    assign lposx = (LW+KIW)'(i_load_pos);

    always_comb begin
        cmp = (32'(i_pos) < 32'(KEYWORD_LEN)) && (32'(i_pos) < 32'(r_klen)) &&
              (r_chars[posx[KIW-1:0]] == i_ch);
        n_mask = r_mask;
        if (i_ctl.start) begin
            n_mask = r_used & cmp;
        end else if (i_ctl.extend) begin
            n_mask = i_ctl.overflow ? 1'b0 : (r_mask & cmp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own  <= i_first;
            r_used <= 1'b0;
            r_mask <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            if (i_ctl.kw_end) begin
                if (r_own) begin
                    r_own  <= 1'b0;
                    r_used <= 1'b1;
                end else if (i_prev_own) begin
                    r_own <= 1'b1;
                end
            end
            if (i_ctl.start || i_ctl.extend) begin
                r_mask <= n_mask;
                r_hit  <= n_mask && (32'(r_klen) == 32'(i_pos) + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_char && r_own) begin
            r_chars[lposx[KIW-1:0]] <= i_ch;
        end
        if (i_ctl.kw_end && r_own) begin
            r_klen <= i_load_pos;
        end
    end

    assign o_own  = r_own;
    assign o_used = r_used;
    assign o_hit  = r_hit;
endmodule

### src/lts_queue.sv
// Result queue between the scanner and the output channel; takes up to two results a cycle.
// Depends on lts_pkg for the result type.
module lts_queue
    import lts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push,
    input  t_res       i_d0,
    input  t_res       i_d1,
    output logic       o_room2,
    output logic       o_valid,
    output t_res       o_res,
    input  logic       i_stall
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    t_res        r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_rd, r_wr;
    logic [AW:0]   r_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_room2 = (r_count <= (AW+1)'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push);
            r_rd    <= r_rd + AW'(pop);
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_d0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_d1;
        end
    end
endmodule

### sim/lts_checker.sv
// Scoreboard for the lexical token scanner: watches both channels, predicts tokens.
// Depends on lts_pkg; instantiated by testbench beside the block.
module lts_checker
    import lts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    input  t_req i_req,
    input  logic i_res_valid,
    input  logic i_res_stall,
    input  t_res i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = KEYWORD_SLOTS_DEF;
    localparam int KLEN  = KEYWORD_LEN_DEF;
    localparam int TLEN  = TOKEN_LEN_DEF;
    localparam int LLEN  = LINE_LEN_DEF;

    logic [7:0]  kw_text [SLOTS][KLEN];
    logic [4:0]  kw_size [SLOTS];
    int          kw_used;
    int          load_pos;
    logic [31:0] hit_mask;
    int          tok_len;
    logic [9:0]  tok_col;
    logic [9:0]  col;
    logic [15:0] line;
    t_mode       mode;
    t_res        token_q[$];

    assign o_pending = token_q.size();

    task automatic push_token(input logic [2:0] kind, input logic [3:0] code,
                              input int kwi, input int len, input logic [9:0] c);
        t_res t;
        t.kind = kind;
        t.code = code;
        t.keyword_index = kwi[4:0];
        t.token_length = len[5:0];
        t.line_number = line;
        t.start_column = c;
        t.last = 1'b0;
        token_q.push_back(t);
    endtask

    task automatic narrow(input logic [7:0] c);
        if (tok_len >= TLEN) begin
            hit_mask = '0;
            return;
        end
        for (int i = 0; i < kw_used; i++) begin
            if (hit_mask[i]) begin
                if (tok_len >= kw_size[i] || tok_len >= KLEN)
                    hit_mask[i] = 1'b0;
                else if (kw_text[i][tok_len] != c)
                    hit_mask[i] = 1'b0;
            end
        end
        tok_len++;
    endtask

    task automatic flush_token();
        case (mode)
            M_IDENT: begin
                for (int i = 0; i < kw_used; i++) begin
                    if (hit_mask[i] && kw_size[i] == tok_len) begin
                        push_token(K_RESERVED, CODE_NONE, i, tok_len, tok_col);
                        mode = M_IDLE;
                        return;
                    end
                end
                push_token(K_IDENT, CODE_NONE, 0, tok_len, tok_col);
            end
            M_NUMBER: push_token(K_INTEGER, CODE_NONE, 0, tok_len, tok_col);
            M_STAR:   push_token(K_OPERATOR, OP_STAR, 0, 0, tok_col);
            M_LT:     push_token(K_OPERATOR, OP_LT, 0, 0, tok_col);
            M_GT:     push_token(K_OPERATOR, OP_GT, 0, 0, tok_col);
            M_COLON:  push_token(K_COLON, CODE_NONE, 0, 0, tok_col);
            default: ;
        endcase
        mode = M_IDLE;
    endtask

    task automatic open_token(input t_mode m, input logic [9:0] c);
        mode = m;
        tok_col = c;
        tok_len = 0;
        hit_mask = '0;
    endtask

    task automatic start_char(input logic [7:0] c, input logic [9:0] at);
        logic [32:0] all;
        if (c == CH_SPACE || c == CH_TAB) return;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            open_token(M_IDENT, at);
            all = (33'd1 << kw_used) - 33'd1;
            hit_mask = all[31:0];
            narrow(c);
            return;
        end
        if (c >= "0" && c <= "9") begin
            open_token(M_NUMBER, at);
            tok_len = 1;
            return;
        end
        case (c)
            CH_STAR:  open_token(M_STAR, at);
            CH_LT:    open_token(M_LT, at);
            CH_GT:    open_token(M_GT, at);
            CH_COLON: open_token(M_COLON, at);
            CH_MINUS: push_token(K_OPERATOR, OP_MINUS, 0, 0, at);
            CH_SLASH: push_token(K_OPERATOR, OP_SLASH, 0, 0, at);
            CH_PLUS:  push_token(K_OPERATOR, OP_PLUS, 0, 0, at);
            CH_EQ:    push_token(K_OPERATOR, OP_EQ, 0, 0, at);
            CH_AT:    push_token(K_OPERATOR, OP_AT, 0, 0, at);
            CH_CARET: push_token(K_OPERATOR, OP_CARET, 0, 0, at);
            CH_LPAR:  push_token(K_DELIM, D_LPAREN, 0, 0, at);
            CH_RPAR:  push_token(K_DELIM, D_RPAREN, 0, 0, at);
            CH_LBRC:  push_token(K_DELIM, D_LBRACE, 0, 0, at);
            CH_RBRC:  push_token(K_DELIM, D_RBRACE, 0, 0, at);
            CH_COMMA: push_token(K_DELIM, D_COMMA, 0, 0, at);
            CH_SEMI:  push_token(K_DELIM, D_SEMI, 0, 0, at);
            default:  push_token(K_BADCHAR, CODE_NONE, 0, 0, at);
        endcase
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic [9:0] at;
        logic taken;
        logic alpha, digit;
        at = col;
        taken = 1'b0;
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit = (c >= "0" && c <= "9");
        case (mode)
            M_IDENT: begin
                if (alpha || digit) begin
                    narrow(c);
                    taken = 1'b1;
                end else flush_token();
            end
            M_NUMBER: begin
                if (digit) begin
                    if (tok_len < TLEN) tok_len++;
                    taken = 1'b1;
                end else begin
                    if (alpha) push_token(K_DIGLET, CODE_NONE, 0, tok_len, tok_col);
                    flush_token();
                end
            end
            M_STAR: begin
                if (c == CH_STAR) begin
                    push_token(K_OPERATOR, OP_POW, 0, 0, tok_col);
                    mode = M_IDLE;
                    taken = 1'b1;
                end else flush_token();
            end
            M_LT: begin
                if (c == CH_GT || c == CH_EQ) begin
                    push_token(K_OPERATOR, (c == CH_GT) ? OP_NE : OP_LE, 0, 0, tok_col);
                    mode = M_IDLE;
                    taken = 1'b1;
                end else flush_token();
            end
            M_GT, M_COLON: begin
                if (c == CH_EQ) begin
                    push_token(K_OPERATOR, (mode == M_GT) ? OP_GE : OP_ASSIGN, 0, 0,
                               tok_col);
                    mode = M_IDLE;
                    taken = 1'b1;
                end else flush_token();
            end
            default: mode = M_IDLE;
        endcase
        if (!taken) start_char(c, at);
        if (col < LLEN - 1) col++;
    endtask

    task automatic take_request(input t_req r);
        int queued;
        queued = token_q.size();
        case (t_cmd'(r.cmd))
            CMD_SRC: scan_char(r.ch);
            CMD_EOL: begin
                flush_token();
                if (line != 16'hFFFF) line++;
                col = '0;
            end
            CMD_KWC: begin
                if (kw_used < SLOTS && load_pos < KLEN) begin
                    kw_text[kw_used][load_pos] = r.ch;
                    load_pos++;
                end
            end
            default: begin
                if (kw_used < SLOTS) begin
                    kw_size[kw_used] = load_pos[4:0];
                    kw_used++;
                end
                load_pos = 0;
            end
        endcase
        if (token_q.size() > queued) token_q[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            kw_used <= 0;
            load_pos <= 0;
            hit_mask <= '0;
            tok_len <= 0;
            tok_col <= '0;
            col <= '0;
            line <= 16'd1;
            mode <= M_IDLE;
            o_errors <= 0;
            o_checked <= 0;
            token_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (token_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected token kind=%0d col=%0d", $realtime,
                                 i_res.kind, i_res.start_column);
                end else begin
                    want = token_q.pop_front();
                    o_checked++;
                    if (want.kind != i_res.kind || want.code != i_res.code ||
                        want.keyword_index != i_res.keyword_index ||
                        want.token_length != i_res.token_length ||
                        want.line_number != i_res.line_number ||
                        want.start_column != i_res.start_column ||
                        want.last != i_res.last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"%0t: mismatch exp kind=%0d code=%0d kw=%0d len=%0d ",
                                      "line=%0d col=%0d last=%0b / got %0d %0d %0d %0d %0d ",
                                      "%0d %0b"}, $realtime, want.kind, want.code,
                                     want.keyword_index, want.token_length,
                                     want.line_number, want.start_column, want.last,
                                     i_res.kind, i_res.code, i_res.keyword_index,
                                     i_res.token_length, i_res.line_number,
                                     i_res.start_column, i_res.last);
                    end
                end
            end
            if (i_valid && !i_stall) take_request(i_req);
        end
    end
endmodule

### sim/testbench.sv
// Top of the scanner testbench: clock, reset, request stimulus and verdict.
// Depends on lts_pkg, lexical_token_scanner_unit and lts_checker.
module testbench
    import lts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_res o_res;
    int   errors, pending, checked;
    int   sent;
    logic calm;
    string words[$];
    string punct[$] = '{"-", "*", "/", "+", "=", "<", ">", "@", "^", "**", "<>", "<=",
                        ">=", ":=", ":", "(", ")", "{", "}", ",", ";"};

    lexical_token_scanner_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    lts_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall(o_stall),
        .i_req(i_req), .i_res_valid(o_valid), .i_res_stall(i_stall), .i_res(o_res),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // calm stretches: no idling on either side
    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(50, 300)) @(posedge i_clk);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int w;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = calm ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic put(input t_cmd cmd, input logic [7:0] ch);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= '{cmd: cmd, ch: ch};
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(CMD_SRC, s[i]);
    endtask

    task automatic load_word(input string s);
        for (int i = 0; i < s.len(); i++) put(CMD_KWC, s[i]);
        put(CMD_KWE, 8'h00);
        words.push_back(s);
    endtask

    function automatic string pick_from(input string set, input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(set[$urandom_range(0, set.len() - 1)])};
        return s;
    endfunction

    initial begin
        int r;
        string s;
        i_valid = 1'b0;
        i_req = '0;
        sent = 0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a word, a zero-length word, then every token class
        load_word("if");
        load_word("");
        put_text("if 7q:a<>*=-/+@^(){},;");
        put(CMD_SRC, 8'hFF);
        put(CMD_SRC, 8'h00);
        put_text("<");
        put(CMD_EOL, 8'h00);

        while (sent < 1250) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                case ($urandom_range(0, 5))
                    0: s = "";
                    1: s = pick_from("abcdefghijklmnopqrst", $urandom_range(17, 20));
                    2: s = pick_from("ab", 16);
                    default: s = pick_from("abcd", $urandom_range(1, 5));
                endcase
                load_word(s);
            end else if (r < 10) begin
                put(CMD_EOL, 8'($urandom_range(0, 255)));
            end else if (r < 30) begin
                if (words.size() > 0 && $urandom_range(0, 1))
                    s = words[$urandom_range(0, words.size() - 1)];
                else if ($urandom_range(0, 15) == 0)
                    s = pick_from("abAB01", 36);
                else
                    s = pick_from("abcdZ01", $urandom_range(1, 6));
                if (s.len() > 0) begin
                    if ($urandom_range(0, 3) == 0) s = {s, pick_from("ab9", 1)};
                    // a word must open with a letter to scan as one
                    if (!((s[0] >= "a" && s[0] <= "z") || (s[0] >= "A" && s[0] <= "Z")))
                        s = {"q", s};
                    put_text(s);
                end
            end else if (r < 42) begin
                s = pick_from("0123456789", ($urandom_range(0, 15) == 0) ? 35
                                                                         : $urandom_range(1, 5));
                if ($urandom_range(0, 2) == 0) s = {s, pick_from("xyZ", 1)};
                put_text(s);
            end else if (r < 62) begin
                put_text(punct[$urandom_range(0, punct.size() - 1)]);
            end else if (r < 80) begin
                put(CMD_SRC, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end else if (r < 90) begin
                put(CMD_SRC, 8'($urandom_range(0, 255)));
            end else if (r < 91 && sent + 1101 <= 1250) begin
                // line long enough to pin the column count
                for (int i = 0; i < 1100; i++)
                    put(CMD_SRC, $urandom_range(0, 3) ? "a" : CH_SPACE);
                put(CMD_EOL, 8'h00);
            end else begin
                put($urandom_range(0, 1) ? CMD_KWC : CMD_KWE, 8'($urandom_range(0, 255)));
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d requests, checked %0d tokens, %0d keywords offered",
                 sent, checked, words.size());
        if (errors == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
